FILE: rtl/itp_pkg.sv
`default_nettype none

package itp_pkg;

  // ascii codes the converter looks at
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig9  = 8'h39;
  localparam logic [7:0] ChTerm  = 8'h00;

  typedef logic [1:0] prec_t;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_OTHER
  } char_class_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_CLOSE,
    ST_POP_OP,
    ST_PUSH,
    ST_END,
    ST_FLUSH,
    ST_TERM
  } state_e;

  typedef enum logic [1:0] {
    SRC_CHAR,
    SRC_TOP,
    SRC_TERM
  } emit_src_e;

  typedef struct packed {
    logic      load_in;
    logic      emit;
    emit_src_e emit_src;
    logic      pop;
    logic      push;
    logic      clear;
  } cmd_t;

  typedef struct packed {
    char_class_e char_class;
    prec_t       char_prec;
    logic        last;
    logic        empty;
    logic        top_open;
    prec_t       top_prec;
    logic        out_free;
  } status_t;

  function automatic prec_t prec_of(input logic [7:0] c);
    prec_t p;
    unique case (c)
      ChPlus, ChMinus: p = 2'd1;
      ChStar, ChSlash: p = 2'd2;
      ChCaret:         p = 2'd3;
      default:         p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e k;
    if ((c >= ChLoA && c <= ChLoZ) || (c >= ChUpA && c <= ChUpZ) ||
        (c >= ChDig0 && c <= ChDig9)) begin
      k = CLS_OPERAND;
    end else if (c == ChOpen) begin
      k = CLS_OPEN;
    end else if (c == ChClose) begin
      k = CLS_CLOSE;
    end else if (prec_of(c) != 2'd0) begin
      k = CLS_OPER;
    end else begin
      k = CLS_OTHER;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/itp_if.sv
`default_nettype none

// infix character channel
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// postfix character channel
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic       overflow;

  modport source (output valid, output out_char, output out_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/infix_to_postfix_converter_core.sv
`default_nettype none

// channel  dir  payload                       handshake
// in_i     in   in_char[7:0], in_last         valid/ready, request taken when both high
// out_o    out  out_char[7:0], out_last,      valid/ready, request taken when both high
//               overflow
//
// one request at a time: accept, decode and a closing step for an operand or an ignored
// character; an open adds a push, an operator pops in a loop and then pushes, and a close
// pops down to its open and drops it, or stops on finding the stack empty
// a last request then flushes the stack top first and sends the terminator
// reset clears the state machine, stack count, overflow flag and output valid, not the ram
// a stalled output holds its register and freezes the pop loop until taken
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  itp_in_if.sink    in_i,
  itp_out_if.source out_o
);
  import itp_pkg::*;

  // control and status between the sequencer and the datapath
  cmd_t    cmd;
  status_t sts;

  // sequencer: decode, pop loops, push, flush and terminator
  itp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: request registers, operator stack, sticky overflow, output register
  itp_dp #(
    .StackDepth(STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_char_i  (in_i.in_char),
    .in_last_i  (in_i.in_last),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_char_o (out_o.out_char),
    .out_last_o (out_o.out_last),
    .overflow_o (out_o.overflow)
  );

endmodule

`default_nettype wire

FILE: rtl/itp_ram.sv
`default_nettype none

module itp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/itp_ctrl.sv
`default_nettype none

module itp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire itp_pkg::status_t sts_i,
  output itp_pkg::cmd_t         cmd_o
);
  import itp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.emit_src = SRC_CHAR;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.char_class)
          CLS_OPERAND: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = ST_END;
            end
          end
          CLS_OPEN:  state_d = ST_PUSH;
          CLS_CLOSE: state_d = ST_POP_CLOSE;
          CLS_OPER:  state_d = ST_POP_OP;
          default:   state_d = ST_END;
        endcase
      end
      // pop down to the matching open paren, which is dropped
      ST_POP_CLOSE: begin
        if (sts_i.empty) begin
          state_d = ST_END;
        end else if (sts_i.top_open) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_END;
        end else if (sts_i.out_free) begin
          cmd_o.pop      = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = SRC_TOP;
        end
      end
      // pop while top binds at least as tight
      ST_POP_OP: begin
        if (!sts_i.empty && sts_i.char_prec <= sts_i.top_prec) begin
          if (sts_i.out_free) begin
            cmd_o.pop      = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.emit_src = SRC_TOP;
          end
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_END;
      end
      // this state also lets the stack read catch up after a write
      ST_END: begin
        state_d = sts_i.last ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (sts_i.empty) begin
          state_d = ST_TERM;
        end else if (sts_i.out_free) begin
          cmd_o.pop      = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = SRC_TOP;
        end
      end
      ST_TERM: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_src = SRC_TERM;
          cmd_o.clear    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/itp_dp.sv
`default_nettype none

module itp_dp #(
  parameter int StackDepth = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     in_char_i,
  input  wire logic           in_last_i,
  input  wire itp_pkg::cmd_t  cmd_i,
  output itp_pkg::status_t    sts_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_char_o,
  output logic                out_last_o,
  output logic                overflow_o
);
  import itp_pkg::*;

  localparam int CntW  = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);

  logic [7:0]      char_q;
  logic            last_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            full;
  logic            wr_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]      top;
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;
  logic            out_ovf_q;

  assign full  = (cnt_q == CntW'(StackDepth));
  assign wr_en = cmd_i.push && !full;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - 1'b1;
    end else if (cmd_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // keep the read port aimed at the next top entry
  always_comb begin
    if (cnt_d == '0) begin
      rd_addr = '0;
    end else begin
      rd_addr = AddrW'(cnt_d - 1'b1);
    end
  end

  itp_ram #(
    .Width(8),
    .Depth(StackDepth)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(AddrW'(cnt_q)),
    .wdata_i(char_q),
    .raddr_i(rd_addr),
    .rdata_o(top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      char_q <= in_char_i;
      last_q <= in_last_i;
    end
    if (cmd_i.emit) begin
      out_ovf_q  <= ovf_q;
      out_last_q <= (cmd_i.emit_src == SRC_TERM);
      case (cmd_i.emit_src)
        SRC_TOP:  out_char_q <= top;
        SRC_TERM: out_char_q <= ChTerm;
        default:  out_char_q <= char_q;
      endcase
    end
  end

  always_comb begin
    sts_o.char_class = classify(char_q);
    sts_o.char_prec  = prec_of(char_q);
    sts_o.last       = last_q;
    sts_o.empty      = (cnt_q == '0);
    sts_o.top_open   = (top == ChOpen);
    sts_o.top_prec   = prec_of(top);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

endmodule

`default_nettype wire

FILE: test/infix_to_postfix_converter_core_test.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_core_test;
  import itp_pkg::*;

  localparam int STACK_DEPTH   = 32;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 80;

  // one postfix request as the output channel carries it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } postfix_t;

  logic clk_i;
  logic rst_ni;

  itp_in_if  in_bus ();
  itp_out_if out_bus ();

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the operator stack, kept in step with accepted requests
  logic [7:0] shadow_stack [STACK_DEPTH];
  int         shadow_depth;
  logic       shadow_ovf;

  // postfix requests still owed by the block, oldest first
  postfix_t postfix_expected [$];

  int mismatch_count;
  int handled_chars;
  int send_idle_pct;
  int recv_stall_pct;

  // ---------------------------------------------------------------------------
  // shunting-yard predictor
  // ---------------------------------------------------------------------------

  // binding strength; '(' and anything else rank 0 so an operator never pops them
  function automatic int op_rank(input logic [7:0] c);
    case (c)
      ChPlus, ChMinus: return 1;
      ChStar, ChSlash: return 2;
      ChCaret:         return 3;
      default:         return 0;
    endcase
  endfunction

  function automatic bit operand_char(input logic [7:0] c);
    return (c >= ChLoA && c <= ChLoZ) || (c >= ChUpA && c <= ChUpZ) ||
           (c >= ChDig0 && c <= ChDig9);
  endfunction

  // the overflow bit reflects the drops made before this entry is owed
  function automatic void owe_char(input logic [7:0] c, input logic last);
    postfix_expected.push_back('{ch: c, last: last, ovf: shadow_ovf});
  endfunction

  // full stack: the push is lost and the sticky flag goes up
  function automatic void shadow_push(input logic [7:0] c);
    if (shadow_depth < STACK_DEPTH) begin
      shadow_stack[shadow_depth] = c;
      shadow_depth++;
    end else begin
      shadow_ovf = 1'b1;
    end
  endfunction

  function automatic void convert_char(input logic [7:0] c, input logic last);
    int rank;
    rank = op_rank(c);
    if (operand_char(c)) begin
      owe_char(c, 1'b0);
      handled_chars++;
    end else if (c == ChOpen) begin
      shadow_push(c);
      handled_chars++;
    end else if (c == ChClose) begin
      // pops down to the matching open; with none stacked it drains everything
      while (shadow_depth > 0 && shadow_stack[shadow_depth - 1] != ChOpen) begin
        owe_char(shadow_stack[shadow_depth - 1], 1'b0);
        shadow_depth--;
      end
      if (shadow_depth > 0) begin
        shadow_depth--;
      end
      handled_chars++;
    end else if (rank != 0) begin
      // equal rank pops too, so every operator binds left to right
      while (shadow_depth > 0 && rank <= op_rank(shadow_stack[shadow_depth - 1])) begin
        owe_char(shadow_stack[shadow_depth - 1], 1'b0);
        shadow_depth--;
      end
      shadow_push(c);
      handled_chars++;
    end
    if (last) begin
      // flush top first, unmatched opens included, then the terminator
      while (shadow_depth > 0) begin
        owe_char(shadow_stack[shadow_depth - 1], 1'b0);
        shadow_depth--;
      end
      owe_char(ChTerm, 1'b1);
      shadow_depth = 0;
      shadow_ovf   = 1'b0;
      if (rank == 0 && !operand_char(c) && c != ChOpen && c != ChClose) begin
        handled_chars++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // valid only drops for an idle gap, never between back-to-back requests
  task automatic send_char(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_char <= c;
    in_bus.in_last <= last;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    convert_char(c, last);
  endtask

  task automatic send_text(input string s, input logic last);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send_char(s[k], last && (k == s.len() - 1));
    end
  endtask

  // hold the input off until the block has handed over everything owed
  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    while (postfix_expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(2))
      0:       return ChLoA + 8'($urandom_range(25));
      1:       return ChUpA + 8'($urandom_range(25));
      default: return ChDig0 + 8'($urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(4))
      0:       return ChPlus;
      1:       return ChMinus;
      2:       return ChStar;
      3:       return ChSlash;
      default: return ChCaret;
    endcase
  endfunction

  // mostly well-formed expressions, some left open, some with stray bytes
  task automatic send_random_expression();
    logic [7:0] text [$];
    int         len;
    int         depth;
    int         k;
    bit         want_operand;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(14, 1);
    depth = 0;
    want_operand = 1'b1;
    for (k = 0; k < len; k++) begin
      if (want_operand) begin
        if (depth < 10 && $urandom_range(3) == 0) begin
          text.push_back(ChOpen);
          depth++;
        end else begin
          text.push_back(rand_operand());
          want_operand = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(2) == 0) begin
        text.push_back(ChClose);
        depth--;
      end else begin
        text.push_back(rand_operator());
        want_operand = 1'b1;
      end
    end
    if ($urandom_range(3) != 0) begin
      while (depth > 0) begin
        text.push_back(ChClose);
        depth--;
      end
    end
    if ($urandom_range(4) == 0) begin
      text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
    end
    if ($urandom_range(7) == 0) begin
      text.push_back(8'($urandom_range(255)));
    end
    for (k = 0; k < text.size(); k++) begin
      send_char(text[k], k == text.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // operand extremes, all five operators, chained '^', parens, a close that
  // finds no open, one left open at the end, stray bytes and a last on a null
  task automatic test_directed();
    send_text("A+9*(z-0)/Z^a^b", 1'b1);
    send_text("a+b))( ", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(ChTerm, 1'b1);
  endtask

  // pile a given number of opens, near or past the stack depth, then an operator on top
  task automatic test_stack_overflow(input int opens);
    int k;
    for (k = 0; k < opens; k++) begin
      send_char(ChOpen, 1'b0);
    end
    send_char(rand_operand(), 1'b0);
    send_char(rand_operator(), 1'b0);
    send_char(rand_operand(), 1'b0);
    send_char(ChClose, 1'b0);
    send_char(rand_operand(), 1'b1);
    // the flag must be clear again in the next expression
    send_text("x*y", 1'b1);
  endtask

  task automatic test_random_expressions(input int count);
    int target;
    target = handled_chars + count;
    while (handled_chars < target) begin
      send_random_expression();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker and output back-pressure
  // ---------------------------------------------------------------------------

  function automatic void report_result(input string what, input postfix_t want,
                                        input postfix_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s: expected char %02h last %0b ovf %0b, got char %02h last %0b ovf %0b",
               what, want.ch, want.last, want.ovf, got.ch, got.last, got.ovf);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    postfix_t got;
    postfix_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{ch: out_bus.out_char, last: out_bus.out_last, ovf: out_bus.overflow};
      if (postfix_expected.size() == 0) begin
        report_result("unexpected request", '0, got);
      end else begin
        want = postfix_expected.pop_front();
        if (got !== want) begin
          report_result("mismatch", want, got);
        end
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("infix_to_postfix_converter_core_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.in_char = 8'h00;
    in_bus.in_last = 1'b0;
    rst_ni         = 1'b0;
    shadow_depth   = 0;
    shadow_ovf     = 1'b0;
    mismatch_count = 0;
    handled_chars  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    wait_for_drain();

    // sender mostly idle
    send_idle_pct  = 77;
    recv_stall_pct = 0;
    test_random_expressions(40);
    test_stack_overflow(STACK_DEPTH);
    wait_for_drain();

    // receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    test_random_expressions(40);
    test_stack_overflow(STACK_DEPTH + 3);
    wait_for_drain();

    // both sides sometimes idle
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    test_random_expressions(40);
    test_stack_overflow($urandom_range(STACK_DEPTH + 2, STACK_DEPTH - 2));

    // full speed
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_expressions(40);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (postfix_expected.size() != 0) begin
      $display("%0d postfix requests never arrived", postfix_expected.size());
      mismatch_count += postfix_expected.size();
    end
    if (mismatch_count == 0) begin
      $display("infix_to_postfix_converter_core_test: done, clean");
    end else begin
      $display("infix_to_postfix_converter_core_test: done, errors");
    end
    $finish;
  end

endmodule
